@@ design/pps_frequency_meter_smoothed_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the PPS frequency meter
// Shared concurrent assertion forms, clocked on the rising edge, with reset
// disable.
// ---------------------------------------------------------------------------
`ifndef PPS_FREQUENCY_METER_SMOOTHED_MACROS_SVH
`define PPS_FREQUENCY_METER_SMOOTHED_MACROS_SVH

// same-cycle implication
`define PFM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pfm_pkg.sv @@
// ---------------------------------------------------------------------------
// pfm_pkg
// Widths, register codes, reset values and beat types of the PPS meter.
// ---------------------------------------------------------------------------
package pfm_pkg;

    localparam int CAP_W     = 16;
    localparam int NOM_W     = 27;
    localparam int SHIFT_W   = 2;
    localparam int PULSE_W   = 8;
    localparam int ERR_W     = 16;
    localparam int FREQ_W    = 31;
    localparam int FRAC_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int NOMN_W    = NOM_W + PULSE_W;

    localparam int DEF_SMOOTH_WEIGHT = 10;
    localparam int FRAC_SCALE        = 1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES  = 2'd2;

    localparam logic [NOM_W-1:0]   NOMINAL_RST = 27'd40000000;
    localparam logic [SHIFT_W-1:0] SHIFT_RST   = 2'd1;
    localparam logic [PULSE_W-1:0] PULSES_RST  = 8'd1;

    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [NOM_W-1:0]     wr_data;
    } t_cfg_wr;

    typedef struct packed {
        logic [NOM_W-1:0]   nominal_clock_hz;
        logic [SHIFT_W-1:0] divider_shift;
        logic [PULSE_W-1:0] pulses_per_result;
    } t_cfg;

    typedef struct packed {
        logic [CAP_W-1:0] capture_time;
    } t_capture;

    typedef struct packed {
        logic signed [ERR_W-1:0] tick_error;
        logic [FREQ_W-1:0]       inst_freq_hz;
        logic [FREQ_W-1:0]       avg_freq_hz;
        logic [FRAC_W-1:0]       avg_frac_millis;
    } t_result;

    // seed ops carry the seed base in freq
    typedef struct packed {
        logic                    is_seed;
        logic signed [ERR_W-1:0] tick_error;
        logic [FREQ_W-1:0]       freq;
    } t_smooth_op;

endpackage

@@ design/pfm_stream_if.sv @@
// ---------------------------------------------------------------------------
// pfm_stream_if
// Valid/ready channel carrying one payload struct per beat.
// ---------------------------------------------------------------------------
interface pfm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/pfm_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// pfm_cfg_regs
// Configuration register file, decoded from the write channel.
// ---------------------------------------------------------------------------
module pfm_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfm_stream_if.sink    i_cfg,
    output pfm_pkg::t_cfg o_cfg
);

    pfm_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nominal_clock_hz  <= pfm_pkg::NOMINAL_RST;
            r_cfg.divider_shift     <= pfm_pkg::SHIFT_RST;
            r_cfg.pulses_per_result <= pfm_pkg::PULSES_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.reg_index)
                pfm_pkg::CFG_NOMINAL: begin
                    r_cfg.nominal_clock_hz <= i_cfg.data.wr_data;
                end
                pfm_pkg::CFG_SHIFT: begin
                    r_cfg.divider_shift <= i_cfg.data.wr_data[pfm_pkg::SHIFT_W-1:0];
                end
                pfm_pkg::CFG_PULSES: begin
                    r_cfg.pulses_per_result <= i_cfg.data.wr_data[pfm_pkg::PULSE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ design/pfm_pulse_stage.sv @@
// ---------------------------------------------------------------------------
// pfm_pulse_stage
// Capture register, pulse countdown and instant frequency; emits seed and
// measurement ops toward the smoother.
// ---------------------------------------------------------------------------
module pfm_pulse_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfm_pkg::t_cfg       i_cfg,
    pfm_stream_if.sink          i_capture,
    output logic                o_op_valid,
    input  logic                i_op_ready,
    output pfm_pkg::t_smooth_op o_op
);

    localparam int CAP_W   = pfm_pkg::CAP_W;
    localparam int PULSE_W = pfm_pkg::PULSE_W;
    localparam int NOMN_W  = pfm_pkg::NOMN_W;
    localparam int FREQ_W  = pfm_pkg::FREQ_W;

    logic                r_in_valid;
    logic [CAP_W-1:0]    r_in_cap;
    logic [CAP_W-1:0]    r_last;
    logic [PULSE_W-1:0]  r_countdown;
    logic                r_seeded;
    logic                r_op_valid;
    pfm_pkg::t_smooth_op r_op;

    logic [PULSE_W-1:0]              w_eff;
    logic [NOMN_W-1:0]               w_nominal_n;
    logic [CAP_W-1:0]                w_raw;
    logic signed [pfm_pkg::ERR_W-1:0] w_err;
    logic signed [NOMN_W+1:0]        w_freq_signed;
    logic [NOMN_W:0]                 w_freq_pos;
    logic [NOMN_W+3:0]               w_freq_shifted;
    logic [FREQ_W-1:0]               w_freq_sat;
    logic [FREQ_W-1:0]               w_base;
    logic                            w_produce;
    logic                            w_s1_free;
    logic                            w_fire;
    pfm_pkg::t_smooth_op             n_op;

    always_comb begin
        w_eff = (i_cfg.pulses_per_result == '0) ? PULSE_W'(1) : i_cfg.pulses_per_result;
        w_nominal_n = NOMN_W'(i_cfg.nominal_clock_hz) * NOMN_W'(w_eff);
        // only the low 16 bits of the nominal count matter for the wrapped error
        w_raw = r_in_cap - r_last - w_nominal_n[CAP_W-1:0];
        w_err = w_raw;
        w_freq_signed = $signed({2'b00, w_nominal_n}) + (NOMN_W+2)'(w_err);
        w_freq_pos = w_freq_signed[NOMN_W+1] ? '0 : w_freq_signed[NOMN_W:0];
        w_freq_shifted = (NOMN_W+4)'(w_freq_pos) << i_cfg.divider_shift;
        w_freq_sat = (|w_freq_shifted[NOMN_W+3:FREQ_W]) ? pfm_pkg::FREQ_MAX
                                                        : w_freq_shifted[FREQ_W-1:0];
        w_base = FREQ_W'(i_cfg.nominal_clock_hz) << i_cfg.divider_shift;

        w_produce = !r_seeded || (r_countdown == PULSE_W'(1));
        w_s1_free = !r_op_valid || i_op_ready;
        w_fire    = r_in_valid && (!w_produce || w_s1_free);

        n_op.is_seed    = !r_seeded;
        n_op.tick_error = w_err;
        n_op.freq       = r_seeded ? w_freq_sat : w_base;
    end

    assign i_capture.ready = !r_in_valid || w_fire;
    assign o_op_valid      = r_op_valid;
    assign o_op            = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_last      <= '0;
            r_countdown <= PULSE_W'(1);
            r_seeded    <= 1'b0;
            r_op_valid  <= 1'b0;
        end else begin
            if (i_capture.ready) begin
                r_in_valid <= i_capture.valid;
            end
            if (w_fire) begin
                if (!r_seeded) begin
                    r_last      <= r_in_cap;
                    r_seeded    <= 1'b1;
                    r_countdown <= w_eff;
                end else if (w_produce) begin
                    r_last      <= r_in_cap;
                    r_countdown <= w_eff;
                end else begin
                    r_countdown <= r_countdown - PULSE_W'(1);
                end
            end
            if (w_fire && w_produce) begin
                r_op_valid <= 1'b1;
            end else if (i_op_ready) begin
                r_op_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_capture.valid && i_capture.ready) begin
            r_in_cap <= i_capture.data.capture_time;
        end
        if (w_fire && w_produce) begin
            r_op <= n_op;
        end
    end

endmodule

@@ design/pfm_smoother.sv @@
// ---------------------------------------------------------------------------
// pfm_smoother
// Running-sum smoother kept as quotient and remainder by the weight, plus
// the result register.
// ---------------------------------------------------------------------------
module pfm_smoother #(
    parameter int SMOOTH_WEIGHT = pfm_pkg::DEF_SMOOTH_WEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    output logic                o_op_ready,
    input  pfm_pkg::t_smooth_op i_op,
    pfm_stream_if.source        o_result
);

    localparam int FREQ_W  = pfm_pkg::FREQ_W;
    localparam int FRAC_W  = pfm_pkg::FRAC_W;
    localparam int REM_L   = $clog2(SMOOTH_WEIGHT);
    localparam int REM_W   = (REM_L > 0) ? REM_L : 1;
    // t = rem + freq + (bias - avg) stays below 2^DIV_N
    localparam int DIV_N   = FREQ_W + 2;
    localparam int RECIP_W = DIV_N + 1;
    localparam int PROD_W  = DIV_N + RECIP_W;
    localparam int QSHIFT  = DIV_N + REM_L;
    localparam int QUOT_W  = PROD_W - QSHIFT;

    // bias keeps the dividend non-negative; it is a whole multiple of the weight
    localparam logic [63:0] BIAS_K = ((64'd1 << FREQ_W) + 64'(SMOOTH_WEIGHT) - 64'd1)
                                     / 64'(SMOOTH_WEIGHT);
    localparam logic [63:0] BIAS   = BIAS_K * 64'(SMOOTH_WEIGHT);
    localparam logic [63:0] RECIP  = ((64'd1 << QSHIFT) / 64'(SMOOTH_WEIGHT)) + 64'd1;

    logic [FREQ_W-1:0]    r_avg;
    logic [REM_W-1:0]     r_rem;
    logic                 r_res_valid;
    pfm_pkg::t_result     r_res;

    logic [FRAC_W-1:0]    w_frac_tbl [SMOOTH_WEIGHT];
    logic [DIV_N-1:0]     w_t;
    logic [PROD_W-1:0]    w_prod;
    logic [QUOT_W-1:0]    w_quot;
    logic [DIV_N:0]       w_avg_sum;
    logic [DIV_N-1:0]     w_rem_full;
    logic [FREQ_W-1:0]    n_avg;
    logic [REM_W-1:0]     n_rem;
    logic                 w_out_free;
    logic                 w_fire;

    for (genvar gi = 0; gi < SMOOTH_WEIGHT; gi++) begin : g_frac
        localparam int FRAC_VAL = (gi * pfm_pkg::FRAC_SCALE) / SMOOTH_WEIGHT;
        assign w_frac_tbl[gi] = FRAC_W'(FRAC_VAL);
    end

    always_comb begin
        w_t = DIV_N'(r_rem) + DIV_N'(i_op.freq) + (DIV_N'(BIAS) - DIV_N'(r_avg));
        w_prod = PROD_W'(w_t) * PROD_W'(RECIP[RECIP_W-1:0]);
        w_quot = w_prod[PROD_W-1:QSHIFT];
        w_avg_sum = (DIV_N+1)'(r_avg) + (DIV_N+1)'(w_quot) - (DIV_N+1)'(BIAS_K);
        w_rem_full = w_t - DIV_N'(DIV_N'(w_quot) * DIV_N'(SMOOTH_WEIGHT));
        if (i_op.is_seed) begin
            n_avg = i_op.freq;
            n_rem = '0;
        end else begin
            n_avg = w_avg_sum[FREQ_W-1:0];
            n_rem = w_rem_full[REM_W-1:0];
        end
        w_out_free = !r_res_valid || o_result.ready;
        // a seed produces no beat, so it never waits on the output
        o_op_ready = i_op.is_seed || w_out_free;
        w_fire     = i_op_valid && o_op_ready;
    end

    assign o_result.valid = r_res_valid;
    assign o_result.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg       <= '0;
            r_rem       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_avg <= n_avg;
                r_rem <= n_rem;
            end
            if (w_fire && !i_op.is_seed) begin
                r_res_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && !i_op.is_seed) begin
            r_res.tick_error      <= i_op.tick_error;
            r_res.inst_freq_hz    <= i_op.freq;
            r_res.avg_freq_hz     <= n_avg;
            r_res.avg_frac_millis <= w_frac_tbl[n_rem];
        end
    end

endmodule

@@ design/pps_frequency_meter_smoothed.sv @@
// ---------------------------------------------------------------------------
// pps_frequency_meter_smoothed
// Timer-capture frequency meter with running-sum smoothing.
// ---------------------------------------------------------------------------
// Channels: i_capture takes one 16-bit timer capture per beat, o_result
// gives one measurement per beat, i_cfg writes the nominal clock, divider
// shift and pulses-per-result registers (always ready, write only while idle).
// The first capture after reset seeds the smoother and gives no beat; after
// that every Nth capture gives one result beat, the others give none.
// Throughput: one capture per cycle while o_result is not held. The smoother state update
// (running average and remainder through a constant-reciprocal multiply)
// is computed combinationally, so measurement captures may follow back to back.
// A capture beat reaches o_result through the capture register, the pulse
// stage register and the result register.
// Reset: registers go to their reset values, the block is unseeded and all
// stage valids clear; no clearing pass is needed.
// Stall: when o_result is held, up to two further measurements queue in the
// internal stage registers before i_capture.ready drops; captures that give
// no result keep flowing while a measurement waits.
// ---------------------------------------------------------------------------
`include "pps_frequency_meter_smoothed_macros.svh"

module pps_frequency_meter_smoothed #(
    parameter int SMOOTH_WEIGHT = pfm_pkg::DEF_SMOOTH_WEIGHT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pfm_stream_if.sink   i_cfg,
    pfm_stream_if.sink   i_capture,
    pfm_stream_if.source o_result
);

    pfm_pkg::t_cfg       w_cfg;
    logic                w_op_valid;
    logic                w_op_ready;
    pfm_pkg::t_smooth_op w_op;

    pfm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    pfm_pulse_stage u_pulse_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_capture  (i_capture),
        .o_op_valid (w_op_valid),
        .i_op_ready (w_op_ready),
        .o_op       (w_op)
    );

    pfm_smoother #(
        .SMOOTH_WEIGHT (SMOOTH_WEIGHT)
    ) u_smoother (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .o_op_ready (w_op_ready),
        .i_op       (w_op),
        .o_result   (o_result)
    );

    `PFM_ASSERT_IMPLY(a_seed_never_waits, i_clk, i_rst_n, w_op_valid && w_op.is_seed, w_op_ready, "seed op stalled at smoother")
    `PFM_ASSERT_IMPLY(a_frac_range, i_clk, i_rst_n, o_result.valid, int'(o_result.data.avg_frac_millis) < pfm_pkg::FRAC_SCALE, "fraction out of range")
    `PFM_ASSERT_IMPLY(a_result_from_op, i_clk, i_rst_n, $rose(o_result.valid), $past(w_op_valid && w_op_ready && !w_op.is_seed), "result beat without a measurement op")
    `PFM_ASSERT_NEXT(a_result_drains, i_clk, i_rst_n, o_result.valid && o_result.ready && !(w_op_valid && w_op_ready && !w_op.is_seed), !o_result.valid, "result beat repeated")

endmodule

@@ test/pps_frequency_meter_smoothed_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_frequency_meter_smoothed_tb
// Drives timer captures and register writes into the PPS frequency meter and
// checks each result beat against an in-bench model of the meter: tick error,
// instant frequency and the smoothed average with its thousandths. A short
// table of directed rows comes first, then randomized register phases with
// mostly well-formed capture spacing. Both handshake sides stall at random.
// ---------------------------------------------------------------------------
module pps_frequency_meter_smoothed_tb;
    import pfm_pkg::*;

    localparam int     WEIGHT      = DEF_SMOOTH_WEIGHT;
    localparam int     ITEMS       = 2000;
    localparam int     LIMIT       = 1000000;
    localparam int     DRAIN_WAIT  = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ROW_CFG,    // register write
        ROW_CAP,    // absolute capture value
        ROW_DELTA   // capture = last measured stamp + value
    } row_kind_e;

    typedef struct {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [NOM_W-1:0]     value;
        bit                   typed;
        int                   exp_err;
        longint               exp_inst;
    } dir_row_t;

    dir_row_t dir_rows [24] = '{
        '{ROW_CAP,   CFG_NOMINAL, 27'h1234,     1'b0, 0,      0},
        '{ROW_DELTA, CFG_NOMINAL, 27'h5A00,     1'b1, 0,      80000000},
        '{ROW_DELTA, CFG_NOMINAL, 27'h5A05,     1'b0, 0,      0},
        '{ROW_CFG,   CFG_NOMINAL, 27'd1,        1'b0, 0,      0},
        '{ROW_CFG,   CFG_SHIFT,   27'd0,        1'b0, 0,      0},
        '{ROW_DELTA, CFG_NOMINAL, 27'hFF9D,     1'b1, -100,   0},
        '{ROW_DELTA, CFG_NOMINAL, 27'h8001,     1'b1, -32768, 0},
        '{ROW_DELTA, CFG_NOMINAL, 27'h8000,     1'b1, 32767,  32768},
        '{ROW_CFG,   CFG_NOMINAL, 27'h7FFFFFF,  1'b0, 0,      0},
        '{ROW_CFG,   CFG_SHIFT,   27'd3,        1'b0, 0,      0},
        '{ROW_DELTA, CFG_NOMINAL, 27'hFFFF,     1'b1, 0,      1073741816},
        '{ROW_CFG,   CFG_PULSES,  27'd3,        1'b0, 0,      0},
        '{ROW_DELTA, CFG_NOMINAL, 27'hFFFD,     1'b1, 0,      2147483647},
        '{ROW_CAP,   CFG_NOMINAL, 27'h0000,     1'b0, 0,      0},
        '{ROW_CAP,   CFG_NOMINAL, 27'hFFFF,     1'b0, 0,      0},
        '{ROW_DELTA, CFG_NOMINAL, 27'h0004,     1'b0, 0,      0},
        '{ROW_CFG,   CFG_PULSES,  27'd0,        1'b0, 0,      0},
        '{ROW_CAP,   CFG_NOMINAL, 27'h5555,     1'b0, 0,      0},
        '{ROW_CAP,   CFG_NOMINAL, 27'hAAAA,     1'b0, 0,      0},
        '{ROW_DELTA, CFG_NOMINAL, 27'hFFFF,     1'b0, 0,      0},
        '{ROW_DELTA, CFG_NOMINAL, 27'h0000,     1'b0, 0,      0},
        '{ROW_CFG,   CFG_NOMINAL, 27'd100000000, 1'b0, 0,     0},
        '{ROW_CFG,   CFG_SHIFT,   27'd2,        1'b0, 0,      0},
        '{ROW_DELTA, CFG_NOMINAL, 27'h1234,     1'b0, 0,      0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pfm_stream_if #(.T(t_cfg_wr))  cfg_bus ();
    pfm_stream_if #(.T(t_capture)) cap_bus ();
    pfm_stream_if #(.T(t_result))  res_bus ();

    pps_frequency_meter_smoothed #(
        .SMOOTH_WEIGHT(WEIGHT)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_bus),
        .i_capture (cap_bus),
        .o_result  (res_bus)
    );

    always #6 i_clk = ~i_clk;

    // meter model: registers and state
    logic [NOM_W-1:0]   nominal_hz;
    logic [SHIFT_W-1:0] div_shift;
    logic [PULSE_W-1:0] pulses_cfg;
    logic [CAP_W-1:0]   last_stamp;
    logic [PULSE_W-1:0] pulses_left;
    bit                 primed;
    logic [39:0]        run_sum;
    logic [31:0]        run_avg;

    t_result pending_results [$];
    t_result head_result;
    int      n_fail;
    int      captures_sent;
    int      cycle_count;
    int      stall_left;
    bit      quiet;
    int      quiet_left;

    function automatic logic [PULSE_W-1:0] pulses_eff();
        return (pulses_cfg == '0) ? PULSE_W'(1) : pulses_cfg;
    endfunction

    function automatic longint unsigned nominal_count();
        return 64'(nominal_hz) * 64'(pulses_eff());
    endfunction

    function automatic bit meter_predict(input logic [CAP_W-1:0] stamp, output t_result r);
        longint unsigned nom_n;
        longint unsigned rem;
        longint unsigned frac;
        longint          freq;
        logic [CAP_W-1:0] raw;
        r = '0;
        if (!primed) begin
            run_sum     = 40'((64'(nominal_hz) << div_shift) * 64'(WEIGHT));
            run_avg     = 32'(64'(run_sum) / 64'(WEIGHT));
            last_stamp  = stamp;
            primed      = 1'b1;
            pulses_left = pulses_eff();
            return 1'b0;
        end
        pulses_left = pulses_left - 1'b1;
        if (pulses_left != '0)
            return 1'b0;
        pulses_left = pulses_eff();

        nom_n      = nominal_count();
        raw        = stamp - last_stamp - nom_n[15:0];
        last_stamp = stamp;

        freq = longint'(nom_n) + longint'($signed(raw));
        if (freq < 0)
            freq = 0;
        freq = freq << div_shift;
        if (freq > longint'(FREQ_MAX))
            freq = longint'(FREQ_MAX);

        run_sum = 40'(64'(run_sum) + 64'(freq) - 64'(run_avg));
        run_avg = 32'(64'(run_sum) / 64'(WEIGHT));
        rem     = 64'(run_sum) - 64'(run_avg) * 64'(WEIGHT);
        frac    = rem * 64'(FRAC_SCALE) / 64'(WEIGHT);

        r.tick_error      = raw;
        r.inst_freq_hz    = freq[FREQ_W-1:0];
        r.avg_freq_hz     = run_avg[FREQ_W-1:0];
        r.avg_frac_millis = frac[FRAC_W-1:0];
        return 1'b1;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [NOM_W-1:0] pick_nominal();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return NOM_W'(1);
        if (r < 30)
            return NOM_W'($urandom_range(2, 40000));
        if (r < 60)
            return NOM_W'(40000000 + int'($urandom_range(0, 2000)) - 1000);
        if (r < 70)
            return NOM_W'(100000000);
        if (r < 80)
            return '1;
        return NOM_W'($urandom);
    endfunction

    function automatic logic [PULSE_W-1:0] pick_pulses();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return PULSE_W'(1);
        if (r < 75)
            return PULSE_W'($urandom_range(2, 4));
        if (r < 85)
            return PULSE_W'($urandom_range(5, 20));
        if (r < 90)
            return '0;
        if (r < 95)
            return '1;
        return PULSE_W'($urandom_range(0, 255));
    endfunction

    // most measurement beats land near the nominal spacing; the rest is noise
    function automatic logic [CAP_W-1:0] make_capture();
        longint unsigned nom_n;
        int              jitter;
        int              r;
        if (primed && pulses_left == PULSE_W'(1) && $urandom_range(0, 9) != 0) begin
            nom_n = nominal_count();
            r     = $urandom_range(0, 99);
            if (r < 70)
                jitter = int'($urandom_range(0, 40)) - 20;
            else if (r < 90)
                jitter = int'($urandom_range(0, 4000)) - 2000;
            else
                jitter = int'($urandom_range(0, 65535));
            return last_stamp + nom_n[15:0] + CAP_W'(jitter);
        end
        return CAP_W'($urandom);
    endfunction

    task automatic send_capture(input logic [CAP_W-1:0] stamp, output bit got,
                                output t_result r);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            cap_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cap_bus.valid <= 1'b1;
        cap_bus.data  <= '{capture_time: stamp};
        do @(posedge i_clk); while (!cap_bus.ready);
        captures_sent++;
        got = meter_predict(stamp, r);
    endtask

    task automatic push_result(input t_result r);
        pending_results.push_back(r);
    endtask

    // block idle: no capture in flight, all results out, pipeline flushed
    task automatic drain();
        cap_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NOM_W-1:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= '{reg_index: idx, wr_data: val};
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_NOMINAL: nominal_hz = val;
            CFG_SHIFT:   div_shift  = val[SHIFT_W-1:0];
            CFG_PULSES:  pulses_cfg = val[PULSE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic shuffle_config();
        logic [NOM_W-1:0] noise;
        noise = NOM_W'($urandom);
        if ($urandom_range(0, 9) < 6)
            write_reg(CFG_NOMINAL, pick_nominal());
        if ($urandom_range(0, 9) < 6)
            write_reg(CFG_SHIFT, {noise[NOM_W-1:SHIFT_W], SHIFT_W'($urandom_range(0, 3))});
        if ($urandom_range(0, 9) < 6)
            write_reg(CFG_PULSES, {noise[NOM_W-1:PULSE_W], pick_pulses()});
        if ($urandom_range(0, 19) == 0)
            write_reg(CFG_UNUSED, noise);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected, actual %p", $time,
                         res_bus.data);
                n_fail++;
            end else begin
                head_result = pending_results.pop_front();
                check_field("tick_error", $signed(head_result.tick_error),
                            $signed(res_bus.data.tick_error));
                check_field("inst_freq_hz", head_result.inst_freq_hz,
                            res_bus.data.inst_freq_hz);
                check_field("avg_freq_hz", head_result.avg_freq_hz,
                            res_bus.data.avg_freq_hz);
                check_field("avg_frac_millis", head_result.avg_frac_millis,
                            res_bus.data.avg_frac_millis);
            end
        end
    end

    always @(posedge i_clk) begin
        int gap;
        if (stall_left != 0) begin
            res_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            gap = pick_gap();
            if (gap != 0) begin
                res_bus.ready <= 1'b0;
                stall_left    <= gap - 1;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // stretches where neither side idles
    always @(posedge i_clk) begin
        if (quiet_left == 0) begin
            quiet      <= ($urandom_range(0, 3) == 0);
            quiet_left <= $urandom_range(50, 400);
        end else begin
            quiet_left <= quiet_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [CAP_W-1:0] stamp;
        t_result          r;
        bit               got;
        int               phase_len;

        i_rst_n       = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data  = '0;
        cap_bus.valid = 1'b0;
        cap_bus.data  = '0;
        res_bus.ready = 1'b0;
        n_fail        = 0;
        captures_sent = 0;
        cycle_count   = 0;
        stall_left    = 0;
        quiet         = 1'b0;
        quiet_left    = 0;

        nominal_hz  = NOMINAL_RST;
        div_shift   = SHIFT_RST;
        pulses_cfg  = PULSES_RST;
        last_stamp  = '0;
        pulses_left = PULSE_W'(1);
        primed      = 1'b0;
        run_sum     = '0;
        run_avg     = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: begin
                    drain();
                    write_reg(dir_rows[i].idx, dir_rows[i].value);
                end
                default: begin
                    stamp = dir_rows[i].value[CAP_W-1:0];
                    if (dir_rows[i].kind == ROW_DELTA)
                        stamp = last_stamp + stamp;
                    send_capture(stamp, got, r);
                    if (got) begin
                        if (dir_rows[i].typed) begin
                            r.tick_error   = ERR_W'(dir_rows[i].exp_err);
                            r.inst_freq_hz = FREQ_W'(dir_rows[i].exp_inst);
                        end
                        push_result(r);
                    end
                end
            endcase
        end

        while (captures_sent < ITEMS) begin
            drain();
            shuffle_config();
            phase_len = $urandom_range(40, 160);
            repeat (phase_len) begin
                send_capture(make_capture(), got, r);
                if (got)
                    push_result(r);
            end
        end

        cap_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
